// ===== hdl/hps_pkg.sv =====
`default_nettype none
package hps_pkg;

  // Pattern command codes
  localparam logic [2:0] MODE_LOW   = 3'd0;
  localparam logic [2:0] MODE_MED   = 3'd1;
  localparam logic [2:0] MODE_HIGH  = 3'd2;
  localparam logic [2:0] MODE_PULSE = 3'd3;
  localparam logic [2:0] MODE_HEART = 3'd4;
  localparam logic [2:0] MODE_WAVE  = 3'd5;

  // Duty levels in percent
  localparam logic [6:0] DUTY_OFF  = 7'd0;
  localparam logic [6:0] DUTY_LOW  = 7'd50;
  localparam logic [6:0] DUTY_MED  = 7'd80;
  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [6:0] DUTY_STEP = 7'd10;
  localparam logic [6:0] WAVE_MIN  = 7'd10;
  localparam logic [6:0] WAVE_TURN = 7'd20;

  // Hold times in ms
  localparam logic [9:0] WAIT_NONE  = 10'd0;
  localparam logic [9:0] WAIT_GAP   = 10'd50;
  localparam logic [9:0] WAIT_PULSE = 10'd100;
  localparam logic [9:0] WAIT_BEAT  = 10'd500;
  localparam logic [9:0] WAIT_REST  = 10'd1000;

  localparam logic [31:0] WAVE_INTERVAL = 32'd100;
  localparam logic [15:0] PERIOD_RESET  = 16'd39;

  // floor(2^29 / 100), quotient estimate is exact or one low below 2^23
  localparam int          RECIP_SHIFT = 29;
  localparam logic [45:0] RECIP_100   = 46'd5368709;

  // Command queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // What the back end expands a queued command into
  typedef enum logic [1:0] {
    KIND_SINGLE,   // one compare write
    KIND_HB_A,     // first heartbeat beat: full, then off
    KIND_HB_B,     // gap, second beat, off
    KIND_HB_C      // closing gap, wait only
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] duty;
    logic       pulse_wait;
  } cmd_t;

  typedef struct packed {
    logic       wr;
    logic [6:0] duty;
    logic [9:0] wait_ms;
    logic       last;
  } op_t;

endpackage
`default_nettype wire

// ===== hdl/hps_front.sv =====
`default_nettype none
module hps_front
  import hps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] now_ms,
  input  wire logic        queue_full,
  output logic             push,
  output cmd_t             cmd
);

  logic [4:0]  phase, phase_next;
  logic [6:0]  wave_level, wave_level_next;
  logic [31:0] last_update_ms, last_update_ms_next;
  logic        accept;
  logic        emit;
  logic [8:0]  up_duty, down_duty;
  logic [4:0]  down_idx;
  logic [6:0]  wave_up, wave_down;
  logic [31:0] elapsed;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && emit;

  assign up_duty   = {4'd0, phase} * 9'd10;
  assign down_idx  = 5'd20 - phase;
  assign down_duty = {4'd0, down_idx} * 9'd10;
  assign wave_up   = wave_level + DUTY_STEP;
  assign wave_down = wave_level - DUTY_STEP;
  assign elapsed   = now_ms - last_update_ms;

  // Classify the command and work out the state it leaves behind
  always_comb begin
    emit                = 1'b0;
    cmd.kind            = KIND_SINGLE;
    cmd.duty            = DUTY_OFF;
    cmd.pulse_wait      = 1'b0;
    phase_next          = phase;
    wave_level_next     = wave_level;
    last_update_ms_next = last_update_ms;
    unique case (mode)
      MODE_LOW: begin
        emit     = 1'b1;
        cmd.duty = DUTY_LOW;
      end
      MODE_MED: begin
        emit     = 1'b1;
        cmd.duty = DUTY_MED;
      end
      MODE_HIGH: begin
        emit     = 1'b1;
        cmd.duty = DUTY_FULL;
      end
      MODE_PULSE: begin
        priority if (phase <= 5'd10) begin
          emit           = 1'b1;
          cmd.duty       = up_duty[6:0];
          cmd.pulse_wait = 1'b1;
          phase_next     = phase + 5'd1;
        end else if (phase <= 5'd20) begin
          emit           = 1'b1;
          cmd.duty       = down_duty[6:0];
          cmd.pulse_wait = 1'b1;
          phase_next     = phase + 5'd1;
        end else begin
          phase_next = 5'd0;
        end
      end
      MODE_HEART: begin
        priority if (phase == 5'd0) begin
          emit       = 1'b1;
          cmd.kind   = KIND_HB_A;
          phase_next = 5'd1;
        end else if (phase == 5'd1) begin
          emit       = 1'b1;
          cmd.kind   = KIND_HB_B;
          phase_next = 5'd2;
        end else if (phase == 5'd2) begin
          emit       = 1'b1;
          cmd.kind   = KIND_HB_C;
          phase_next = 5'd0;
        end else begin
          // phase outside the beat: hold
          phase_next = phase;
        end
      end
      MODE_WAVE: begin
        if (elapsed >= WAVE_INTERVAL) begin
          last_update_ms_next = now_ms;
          priority if (phase == 5'd0) begin
            emit     = 1'b1;
            cmd.duty = wave_level;
            if (wave_up >= DUTY_FULL) begin
              wave_level_next = DUTY_FULL;
              phase_next      = 5'd1;
            end else begin
              wave_level_next = wave_up;
            end
          end else if (phase == 5'd1) begin
            emit     = 1'b1;
            cmd.duty = wave_level;
            if (wave_level <= WAVE_TURN) begin
              wave_level_next = WAVE_MIN;
              phase_next      = 5'd0;
            end else begin
              wave_level_next = wave_down;
            end
          end else begin
            // phase outside the wave: only the stamp moves
            wave_level_next = wave_level;
          end
        end
      end
      default: begin
        emit     = 1'b1;
        cmd.duty = DUTY_OFF;
      end
    endcase
  end

  // Commit pattern state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= 5'd0;
      wave_level     <= DUTY_FULL;
      last_update_ms <= 32'd0;
    end else if (accept) begin
      phase          <= phase_next;
      wave_level     <= wave_level_next;
      last_update_ms <= last_update_ms_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hps_queue.sv =====
`default_nettype none
module hps_queue
  import hps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  cmd_t      push_cmd,
  output logic      full,
  input  wire logic pop,
  output logic      empty,
  output cmd_t      head
);

  cmd_t                entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full  = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      if (push && !pop) begin
        count <= count + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/hps_back.sv =====
`default_nettype none
module hps_back
  import hps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [15:0] pwm_period,
  input  wire logic        empty,
  input  cmd_t             head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_write,
  output logic [16:0]      out_compare,
  output logic [9:0]       out_wait,
  output logic             out_last
);

  logic        adv;
  logic        issue;
  logic [1:0]  idx;
  op_t         op;

  logic        s1_valid;
  op_t         s1_op;
  logic [22:0] s1_prod;
  logic        s2_valid;
  op_t         s2_op;
  logic [22:0] s2_prod;
  logic [16:0] s2_q0;

  logic [16:0] scale;
  logic [23:0] full_prod;
  logic [45:0] recip_prod;
  logic [23:0] q_times;
  logic [23:0] rem;

  // Whole pipe moves when the output register is free or being taken
  assign adv   = !out_valid || out_ready;
  assign issue = adv && !empty;
  assign pop   = issue && op.last;

  // Expand the head command into its current result
  always_comb begin
    op.wr      = 1'b1;
    op.duty    = DUTY_OFF;
    op.wait_ms = WAIT_NONE;
    op.last    = 1'b1;
    unique case (head.kind)
      KIND_SINGLE: begin
        op.duty    = head.duty;
        op.wait_ms = head.pulse_wait ? WAIT_PULSE : WAIT_NONE;
      end
      KIND_HB_A: begin
        if (idx == 2'd0) begin
          op.duty    = DUTY_FULL;
          op.wait_ms = WAIT_BEAT;
          op.last    = 1'b0;
        end
      end
      KIND_HB_B: begin
        unique case (idx)
          2'd0: begin
            op.wr      = 1'b0;
            op.wait_ms = WAIT_GAP;
            op.last    = 1'b0;
          end
          2'd1: begin
            op.duty    = DUTY_MED;
            op.wait_ms = WAIT_REST;
            op.last    = 1'b0;
          end
          default: begin
            op.duty = DUTY_OFF;
          end
        endcase
      end
      KIND_HB_C: begin
        op.wr      = 1'b0;
        op.wait_ms = WAIT_GAP;
      end
      default: begin
        op.duty = DUTY_OFF;
      end
    endcase
  end

  // Step through the results of one command
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (issue) begin
      idx <= op.last ? 2'd0 : idx + 2'd1;
    end
  end

  assign scale      = {1'b0, pwm_period} + 17'd1;
  assign full_prod  = {7'd0, scale} * {17'd0, op.duty};
  assign recip_prod = {23'd0, s1_prod} * RECIP_100;
  assign q_times    = {7'd0, s2_q0} * 24'd100;
  assign rem        = {1'b0, s2_prod} - q_times;

  // Valid bits of the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= issue;
      s2_valid  <= s1_valid;
      out_valid <= s2_valid;
    end
  end

  // Scale duty, estimate the quotient, then correct it
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op       <= op;
      s1_prod     <= full_prod[22:0];
      s2_op       <= s1_op;
      s2_prod     <= s1_prod;
      s2_q0       <= recip_prod[RECIP_SHIFT+16:RECIP_SHIFT];
      out_write   <= s2_op.wr;
      out_compare <= s2_q0 + 17'(rem >= 24'd100);
      out_wait    <= s2_op.wait_ms;
      out_last    <= s2_op.last;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/haptic_pattern_sequencer.sv =====
// Haptic pattern sequencer. Each input word is a pattern command (mode in
// s_tdata[2:0], millisecond tick in s_tdata[34:3]); each output word is one
// motor step: a PWM compare write or a wait-only step, with the hold time in
// ms and tlast on the final step of the command. Steady modes give one step,
// pulsing and wave one step or none, heartbeat up to three. The front end
// takes one command per cycle while its four-entry command queue has room;
// the back end expands queued commands at one output word per cycle while
// m_tready takes them, so output rate sets the sustained rate; a command
// with no steps uses only its input slot. Duty to compare conversion is a
// three-stage pipe (s1, s2, output register) that a command's first step
// passes through after it is queued. Write pwm_period only while the block
// is idle; cfg_ready is always high.
`default_nettype none
module haptic_pattern_sequencer
  import hps_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data,       // pwm_period
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,        // mode[2:0], now_ms[34:3], zero pad
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,        // write_compare[0], compare_value[17:1],
                                           // wait_ms[27:18], zero pad
  output logic             m_tlast
);

  logic [15:0] pwm_period;
  logic        queue_full, queue_empty;
  logic        push, pop;
  cmd_t        push_cmd, head;
  logic        out_write;
  logic [16:0] out_compare;
  logic [9:0]  out_wait;

  assign cfg_ready = 1'b1;

  // Hold the period register
  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period <= PERIOD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      pwm_period <= cfg_data;
    end
  end

  hps_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .mode       (s_tdata[2:0]),
    .now_ms     (s_tdata[34:3]),
    .queue_full (queue_full),
    .push       (push),
    .cmd        (push_cmd)
  );

  hps_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  hps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pwm_period  (pwm_period),
    .empty       (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_write   (out_write),
    .out_compare (out_compare),
    .out_wait    (out_wait),
    .out_last    (m_tlast)
  );

  assign m_tdata = {4'd0, out_wait, out_compare, out_write};

endmodule
`default_nettype wire

// ===== hdl/hps_checker.sv =====
`default_nettype none
module hps_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic        m_tlast
);

  // Reset empties the output register
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output word changed");

  // Wait-only steps carry a zero compare and the short gap
  a_wait_only: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[17:1] == 17'd0 && m_tdata[27:18] == 10'd50)
    else $error("malformed wait-only step");

  // Hold times come from the fixed set
  a_wait_set: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[27:18] == 10'd0 || m_tdata[27:18] == 10'd50 ||
                 m_tdata[27:18] == 10'd100 || m_tdata[27:18] == 10'd500 ||
                 m_tdata[27:18] == 10'd1000)
    else $error("unexpected hold time");

endmodule

bind haptic_pattern_sequencer hps_checker u_hps_checker (.*);
`default_nettype wire
